FILE: src/rlebe_pkg.sv
// Shared types and constants for the run-length byte encoder.
`default_nettype none

package rlebe_pkg;

    // Default sizing of the encoder.
    localparam int MAX_LITERAL_DEF = 128;
    localparam int MIN_RUN_DEF     = 3;

    // Count byte written when a run hits its length cap.
    localparam int RUN_CAP_CNT = 127;

    // Marker bit of a literal block header.
    localparam logic [7:0] LIT_FLAG = 8'(1 << 7);

    // Width of the run length counter; it never exceeds RUN_CAP_CNT + MIN_RUN - 1.
    localparam int RUN_W = 8;

    // Output word packing.
    localparam int WORD_BYTES  = 8;
    localparam int PEND_BYTES  = WORD_BYTES - 1;
    localparam int PEND_CNT_W  = $clog2(WORD_BYTES);
    localparam int OUT_CNT_W   = 4;
    localparam int OUT_DATA_W  = 8 * WORD_BYTES;
    localparam int OUT_TDATA_W = 72;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;      // take one input transfer and update the state
        logic push_cnt;  // send the count byte of a run pair
        logic push_val;  // send the value byte of a run pair
        logic spill;     // move one held byte into the literal store
        logic hdr;       // send a literal block header, start reading
        logic lit;       // send one stored literal byte
        logic fin;       // send the closing word and clear the state
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eos;
        logic in_run;
        logic run_match;
        logic run_cap;
        logic run_long;
        logic win_last;
        logic win_same;
        logic lit_any;
        logic lit_hit;
        logic spill_done;
        logic blk_last;
        logic flush_done;
    } t_dp_status;

    // Byte or closing word request from the datapath to the packer.
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       fin;
    } t_pack_req;

    // Space available in the packer.
    typedef struct packed {
        logic byte_ready;
        logic out_free;
    } t_pack_status;

endpackage

`default_nettype wire

FILE: src/rle_byte_encoder_core.sv
// Top level of the run-length byte encoder.
// Bytes arrive one per transfer on the slave stream; tlast marks the end of a
// stream, and the data of that transfer is ignored. Literal blocks go out as a
// header 0x80|(n-1) and n bytes, runs as the pair (count-MIN_RUN, byte), all
// packed into 8-byte words with the first byte in the lowest lane. A run pair
// is sent as two bytes, and a literal block of n bytes as n+1 bytes, read one
// by one through the single read port of the literal store. The end of stream
// sends any open run pair, moves held bytes into the store, then flushes it,
// then sends the closing word, which carries tlast and may hold zero bytes. No
// new byte is accepted while tokens of the previous one are being sent; the
// output register lets a finished word wait for the consumer while work goes
// on, and output back-pressure stalls byte sending only when both the word
// being built and the output register are full.
`default_nettype none

module rle_byte_encoder_core #(
    parameter int MAX_LITERAL = rlebe_pkg::MAX_LITERAL_DEF,
    parameter int MIN_RUN     = rlebe_pkg::MIN_RUN_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0 up: data_byte (8).
    input  wire  [7:0]                        s_axis_tdata,
    input  wire                               s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // Fields from bit 0 up: out_bytes (64), byte_count (4), zero fill (4).
    output logic [rlebe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);
    import rlebe_pkg::*;

    t_dp_cmd      dp_cmd;
    t_dp_status   dp_status;
    t_pack_req    pack_req;
    t_pack_status pack_status;

    // Sequencing.
    rlebe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_dp       (dp_status),
        .i_pk       (pack_status),
        .o_cmd      (dp_cmd)
    );

    // Window, run and literal state.
    rlebe_dpath #(
        .MAX_LITERAL (MAX_LITERAL),
        .MIN_RUN     (MIN_RUN)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (s_axis_tdata),
        .i_eos      (s_axis_tlast),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_pack_req (pack_req)
    );

    // Word packing and output register.
    rlebe_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (pack_req),
        .o_status   (pack_status),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: src/rlebe_pack.sv
// Output packer: gathers token bytes into 8-byte words behind an output register.
`default_nettype none

module rlebe_pack (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  rlebe_pkg::t_pack_req              i_req,
    output rlebe_pkg::t_pack_status           o_status,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // Fields from bit 0 up: out_bytes (64), byte_count (4), zero fill (4).
    output logic [rlebe_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                              o_m_tlast
);
    import rlebe_pkg::*;

    localparam int PEND_W = 8 * PEND_BYTES;

    logic [PEND_W-1:0]     r_pend;
    logic [PEND_CNT_W-1:0] r_pend_n;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_CNT_W-1:0]  r_out_cnt;
    logic                  r_out_last;
    logic                  out_free;
    logic                  pend_full;

    // The output register frees up when its word is taken in this cycle.
    assign out_free  = !r_out_valid || i_m_tready;
    assign pend_full = (r_pend_n == PEND_CNT_W'(PEND_BYTES));

    assign o_status.out_free   = out_free;
    assign o_status.byte_ready = !pend_full || out_free;

    // Pending bytes and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_pend_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((i_req.push && pend_full) || i_req.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_req.push && pend_full) begin
                r_pend      <= '0;
                r_pend_n    <= '0;
            end else if (i_req.push) begin
                r_pend_n <= r_pend_n + 1'b1;
                for (int k = 0; k < PEND_BYTES; k++) begin
                    if (r_pend_n == PEND_CNT_W'(k)) begin
                        r_pend[8*k +: 8] <= i_req.data;
                    end
                end
            end else if (i_req.fin) begin
                r_pend      <= '0;
                r_pend_n    <= '0;
            end
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (i_req.push && pend_full) begin
            r_out_data <= {i_req.data, r_pend};
            r_out_cnt  <= OUT_CNT_W'(WORD_BYTES);
            r_out_last <= 1'b0;
        end else if (i_req.fin) begin
            r_out_data <= {8'h00, r_pend};
            r_out_cnt  <= OUT_CNT_W'(r_pend_n);
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_DATA_W - OUT_CNT_W)'(0), r_out_cnt, r_out_data};

`ifndef SYNTH
    // A byte is only pushed when the packer has room for it.
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> o_status.byte_ready)
        else $error("byte pushed while packer is full");

    // The closing word is only sent when the output register is free.
    a_fin_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.fin |-> o_status.out_free)
        else $error("closing word sent while output register is busy");

    // Every word except the closing one is full.
    a_full_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_cnt == OUT_CNT_W'(WORD_BYTES)))
        else $error("inner word is not full");
`endif

endmodule

`default_nettype wire

FILE: src/rlebe_dpath.sv
// Encoder datapath: byte window, run tracking and the literal store.
`default_nettype none

module rlebe_dpath #(
    parameter int MAX_LITERAL = rlebe_pkg::MAX_LITERAL_DEF,
    parameter int MIN_RUN     = rlebe_pkg::MIN_RUN_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  [7:0]              i_data,
    input  wire                     i_eos,
    input  rlebe_pkg::t_dp_cmd      i_cmd,
    output rlebe_pkg::t_dp_status   o_status,
    output rlebe_pkg::t_pack_req    o_pack_req
);
    import rlebe_pkg::*;

    localparam int WIN       = MIN_RUN - 1;
    localparam int FW        = $clog2(MIN_RUN);
    localparam int LIT_DEPTH = MAX_LITERAL + MIN_RUN - 1;
    localparam int AW        = $clog2(LIT_DEPTH);
    localparam int LW        = $clog2(LIT_DEPTH + 1);
    localparam int RUN_TOP   = RUN_CAP_CNT + MIN_RUN;

    logic [7:0]       r_win [WIN];
    logic [FW-1:0]    r_fill;
    logic [7:0]       r_mem [LIT_DEPTH];
    logic [LW-1:0]    r_lit_len;
    logic [LW-1:0]    r_pos;
    logic [LW-1:0]    r_blk_left;
    logic             r_in_run;
    logic [7:0]       r_run_val;
    logic [RUN_W-1:0] r_run_len;
    logic [7:0]       r_pair_cnt;
    logic [7:0]       r_pair_val;
    logic [7:0]       r_rd_data;

    logic [7:0]       win_up   [WIN];
    logic [7:0]       win_down [WIN];
    logic             run_match;
    logic             run_long;
    logic             run_cap;
    logic             win_last;
    logic             win_same;
    logic             spill_done;
    logic             blk_last;
    logic             flush_done;
    logic             lead_none;
    logic [LW-1:0]    rem;
    logic [LW-1:0]    blk;
    logic [7:0]       hdr_byte;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;

    // Window shifted by one: toward the new byte, or emptied from the top.
    for (genvar g = 0; g < WIN; g++) begin : g_shift
        if (g < WIN - 1) begin : g_mid
            assign win_up[g]   = r_win[g+1];
            assign win_down[g] = r_win[g+1];
        end else begin : g_top
            assign win_up[g]   = i_data;
            assign win_down[g] = r_win[g];
        end
    end

    // Decisions on the incoming byte and the held state.
    assign run_match  = (i_data == r_run_val);
    assign run_long   = (r_run_len >= RUN_W'(MIN_RUN));
    assign run_cap    = (r_run_len >= RUN_W'(RUN_TOP - 1));
    assign win_last   = (r_fill == FW'(WIN));
    assign spill_done = r_in_run ? (r_run_len == '0) : (r_fill == '0);
    assign blk_last   = (r_blk_left == LW'(1));
    assign flush_done = (r_pos == r_lit_len);
    // A broken run leaves no copies behind when its pair went out or it was empty.
    assign lead_none  = run_long || (r_run_len == '0);

    always_comb begin
        win_same = 1'b1;
        for (int i = 0; i < WIN; i++) begin
            if (r_win[i] != i_data) begin
                win_same = 1'b0;
            end
        end
    end

    // Size of the next literal block and its header byte.
    assign rem      = r_lit_len - r_pos;
    assign blk      = (rem > LW'(MAX_LITERAL)) ? LW'(MAX_LITERAL) : rem;
    assign hdr_byte = LIT_FLAG | {1'b0, 7'(blk - LW'(1))};

    assign o_status.eos        = i_eos;
    assign o_status.in_run     = r_in_run;
    assign o_status.run_match  = run_match;
    assign o_status.run_cap    = run_cap;
    assign o_status.run_long   = run_long;
    assign o_status.win_last   = win_last;
    assign o_status.win_same   = win_same;
    assign o_status.lit_any    = (r_lit_len != '0);
    assign o_status.lit_hit    = (r_lit_len == LW'(MAX_LITERAL - 1));
    assign o_status.spill_done = spill_done;
    assign o_status.blk_last   = blk_last;
    assign o_status.flush_done = flush_done;

    // Literal store write: the oldest window byte, a run byte, or the new byte.
    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_win[0];
        if (i_cmd.step && !i_eos) begin
            if (r_in_run) begin
                if (!run_match) begin
                    wr_en   = 1'b1;
                    wr_data = lead_none ? i_data : r_run_val;
                end
            end else if (win_last && !win_same) begin
                wr_en   = 1'b1;
                wr_data = r_win[0];
            end
        end else if (i_cmd.spill && !spill_done) begin
            wr_en   = 1'b1;
            wr_data = r_in_run ? r_run_val : r_win[0];
        end
    end

    // Reads run one byte ahead of the byte being sent.
    assign rd_en = i_cmd.hdr || (i_cmd.lit && !blk_last);

    // Literal store.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_lit_len[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_pos[AW-1:0]];
        end
    end

    // Counters and run flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_lit_len  <= '0;
            r_pos      <= '0;
            r_blk_left <= '0;
            r_in_run   <= 1'b0;
            r_run_val  <= '0;
            r_run_len  <= '0;
        end else begin
            if (wr_en) begin
                r_lit_len <= r_lit_len + 1'b1;
            end
            if (i_cmd.step) begin
                if (i_eos) begin
                    if (r_in_run && run_long) begin
                        r_run_len <= '0;
                    end
                end else if (r_in_run) begin
                    if (run_match) begin
                        r_run_len <= run_cap ? '0 : r_run_len + 1'b1;
                    end else begin
                        r_in_run  <= 1'b0;
                        r_run_len <= '0;
                        r_fill    <= lead_none ? '0 : FW'(r_run_len);
                    end
                end else if (win_last) begin
                    if (win_same) begin
                        r_in_run  <= 1'b1;
                        r_run_val <= i_data;
                        r_run_len <= RUN_W'(MIN_RUN);
                        r_fill    <= '0;
                    end
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_cmd.spill && !spill_done) begin
                if (r_in_run) begin
                    r_run_len <= r_run_len - 1'b1;
                end else begin
                    r_fill <= r_fill - 1'b1;
                end
            end else if (i_cmd.hdr) begin
                r_blk_left <= blk;
                r_pos      <= r_pos + 1'b1;
            end else if (i_cmd.lit) begin
                if (!blk_last) begin
                    r_blk_left <= r_blk_left - 1'b1;
                    r_pos      <= r_pos + 1'b1;
                end else if (flush_done) begin
                    r_pos     <= '0;
                    r_lit_len <= '0;
                end
            end else if (i_cmd.fin) begin
                r_fill    <= '0;
                r_lit_len <= '0;
                r_pos     <= '0;
                r_in_run  <= 1'b0;
                r_run_val <= '0;
                r_run_len <= '0;
            end
        end
    end

    // Window contents and the pending run pair.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pair_val <= r_run_val;
            r_pair_cnt <= (r_in_run && run_match && !i_eos) ? 8'(RUN_CAP_CNT)
                                                             : 8'(r_run_len - RUN_W'(MIN_RUN));
            if (!i_eos) begin
                if (r_in_run) begin
                    if (!run_match) begin
                        // Leftover run copies followed by the new byte.
                        for (int i = 0; i < WIN; i++) begin
                            r_win[i] <= (r_run_len == RUN_W'(i + 1)) ? i_data : r_run_val;
                        end
                    end
                end else if (win_last) begin
                    if (!win_same) begin
                        for (int i = 0; i < WIN; i++) begin
                            r_win[i] <= win_up[i];
                        end
                    end
                end else begin
                    for (int i = 0; i < WIN; i++) begin
                        if (r_fill == FW'(i)) begin
                            r_win[i] <= i_data;
                        end
                    end
                end
            end
        end else if (i_cmd.spill && !spill_done && !r_in_run) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= win_down[i];
            end
        end
    end

    // Byte sent to the packer.
    always_comb begin
        o_pack_req.push = i_cmd.push_cnt || i_cmd.push_val || i_cmd.hdr || i_cmd.lit;
        o_pack_req.fin  = i_cmd.fin;
        if (i_cmd.push_cnt) begin
            o_pack_req.data = r_pair_cnt;
        end else if (i_cmd.push_val) begin
            o_pack_req.data = r_pair_val;
        end else if (i_cmd.hdr) begin
            o_pack_req.data = hdr_byte;
        end else begin
            o_pack_req.data = r_rd_data;
        end
    end

`ifndef SYNTH
    // The literal store never overflows.
    a_lit_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lit_len <= LW'(LIT_DEPTH - 1))
        else $error("literal store overflow");

    // An open run holds no bytes in the window.
    a_run_win : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_fill == '0))
        else $error("window not empty while a run is open");

    // The run counter wraps before reaching the cap.
    a_run_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_len < RUN_W'(RUN_TOP))
        else $error("run length beyond cap");
`endif

endmodule

`default_nettype wire

FILE: src/rlebe_ctrl.sv
// Encoder controller: sequences pair tokens, literal flushes and the stream end.
`default_nettype none

module rlebe_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_tvalid,
    output logic                      o_s_tready,
    input  rlebe_pkg::t_dp_status     i_dp,
    input  rlebe_pkg::t_pack_status   i_pk,
    output rlebe_pkg::t_dp_cmd        o_cmd
);
    import rlebe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAIR_CNT,
        S_PAIR_VAL,
        S_SPILL,
        S_HDR,
        S_LIT,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_eos;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (r_in_ready && i_s_tvalid) begin
                    o_cmd.step = 1'b1;
                    if (i_dp.eos) begin
                        n_state = (i_dp.in_run && i_dp.run_long) ? S_PAIR_CNT : S_SPILL;
                    end else if (i_dp.in_run) begin
                        if (i_dp.run_match ? i_dp.run_cap : i_dp.run_long) begin
                            n_state = S_PAIR_CNT;
                        end
                    end else if (i_dp.win_last &&
                                 (i_dp.win_same ? i_dp.lit_any : i_dp.lit_hit)) begin
                        n_state = S_HDR;
                    end
                end
            end
            S_PAIR_CNT: begin
                if (i_pk.byte_ready) begin
                    o_cmd.push_cnt = 1'b1;
                    n_state        = S_PAIR_VAL;
                end
            end
            S_PAIR_VAL: begin
                if (i_pk.byte_ready) begin
                    o_cmd.push_val = 1'b1;
                    n_state        = r_eos ? S_SPILL : S_IDLE;
                end
            end
            S_SPILL: begin
                // One held byte moves to the literal store per cycle.
                if (i_dp.spill_done) begin
                    n_state = i_dp.lit_any ? S_HDR : S_FINAL;
                end else begin
                    o_cmd.spill = 1'b1;
                end
            end
            S_HDR: begin
                if (i_pk.byte_ready) begin
                    o_cmd.hdr = 1'b1;
                    n_state   = S_LIT;
                end
            end
            S_LIT: begin
                if (i_pk.byte_ready) begin
                    o_cmd.lit = 1'b1;
                    if (i_dp.blk_last) begin
                        if (!i_dp.flush_done) begin
                            n_state = S_HDR;
                        end else begin
                            n_state = r_eos ? S_FINAL : S_IDLE;
                        end
                    end
                end
            end
            S_FINAL: begin
                if (i_pk.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, input ready and the stream end flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_eos      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
            if (o_cmd.step) begin
                r_eos <= i_dp.eos;
            end
        end
    end

    assign o_s_tready = r_in_ready;

endmodule

`default_nettype wire
